>>> hw/rtl/pbm_pkg.sv
`default_nettype none

package pbm_pkg;

  // Arctangent table, atan(2^-i) in Q2.30, rounded to nearest
  localparam int ATAN_LEN = 32;
  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0};

  // Square root and quotient each resolve one bit per stage
  localparam int ROOT_BITS = 32;
  localparam int QUO_BITS  = 32;

  // Rotation output range
  localparam logic [18:0] ROT_MAX = 19'h3FFFF;
  localparam logic [18:0] ROT_MIN = 19'h40000;

  // Item state carried down the pipeline
  typedef struct packed {
    logic [2:0][32:0] diff;   // position difference, signed
    logic [2:0]       neg;    // sign of each rotation component
    logic [2:0][31:0] u;      // halved vector magnitudes
    logic [31:0]      wh;     // halved scalar part, non-negative
    logic [63:0]      s;      // sum of squares of u
    logic [31:0]      n;      // floor square root of s
    logic [31:0]      theta;  // rotation angle, Q2.30
  } pbm_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/pbm_quat.sv
`default_nettype none

module pbm_quat (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [319:0]       in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pbm_pkg::pbm_item_t      out_item
);

  localparam int NS = 4;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vld_src;

  // Per-stage ready: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_src   = {vld[NS-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  // Unpack fields
  logic signed [31:0] pos [6];
  logic signed [15:0] ax, ay, az, aw, bx, by, bz, bw;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pos[k] = in_data[32*k +: 32];
    end
    bx = in_data[223:208];
    by = in_data[207:192];
    bz = in_data[255:240];
    bw = in_data[239:224];
    ax = in_data[287:272];
    ay = in_data[271:256];
    az = in_data[319:304];
    aw = in_data[303:288];
  end

  // Stage 0: position difference and the sixteen partial products
  logic signed [32:0] diff0 [3];
  logic signed [31:0] prod  [16];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        diff0[k] <= 33'(pos[k]) - 33'(pos[3+k]);
      end
      prod[0]  <= aw * bw;
      prod[1]  <= ax * bx;
      prod[2]  <= ay * by;
      prod[3]  <= az * bz;
      prod[4]  <= aw * bx;
      prod[5]  <= bw * ax;
      prod[6]  <= ay * bz;
      prod[7]  <= az * by;
      prod[8]  <= aw * by;
      prod[9]  <= bw * ay;
      prod[10] <= az * bx;
      prod[11] <= ax * bz;
      prod[12] <= aw * bz;
      prod[13] <= bw * az;
      prod[14] <= ax * by;
      prod[15] <= ay * bx;
    end
  end

  // Stage 1: sum products, flip to the short rotation, take magnitudes
  logic signed [33:0] w_sum, w_abs;
  logic signed [33:0] v_sum [3];
  logic signed [33:0] v_fix [3];
  logic signed [33:0] v_mag [3];
  logic               w_neg;

  always_comb begin
    w_sum = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
    w_neg = w_sum[33];
    w_abs = w_neg ? -w_sum : w_sum;
    for (int k = 0; k < 3; k++) begin
      v_sum[k] = 34'(prod[4+4*k]) - 34'(prod[5+4*k]) - 34'(prod[6+4*k])
               + 34'(prod[7+4*k]);
      v_fix[k] = w_neg ? -v_sum[k] : v_sum[k];
      v_mag[k] = v_fix[k][33] ? -v_fix[k] : v_fix[k];
    end
  end

  logic [32:0] diff1 [3];
  logic [2:0]  neg1;
  logic [31:0] u1 [3];
  logic [31:0] wh1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) begin
        diff1[k] <= diff0[k];
        neg1[k]  <= v_fix[k][33];
        u1[k]    <= v_mag[k][32:1];
      end
      wh1 <= w_abs[32:1];
    end
  end

  // Stage 2: squares
  logic [32:0] diff2 [3];
  logic [2:0]  neg2;
  logic [31:0] u2 [3];
  logic [31:0] wh2;
  logic [63:0] sq [3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int k = 0; k < 3; k++) begin
        diff2[k] <= diff1[k];
        u2[k]    <= u1[k];
        sq[k]    <= u1[k] * u1[k];
      end
      neg2 <= neg1;
      wh2  <= wh1;
    end
  end

  // Stage 3: sum of squares
  pbm_pkg::pbm_item_t itm3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        itm3.diff[k] <= diff2[k];
        itm3.u[k]    <= u2[k];
      end
      itm3.neg   <= neg2;
      itm3.wh    <= wh2;
      itm3.s     <= sq[0] + sq[1] + sq[2];
      itm3.n     <= '0;
      itm3.theta <= '0;
    end
  end

  assign out_item = itm3;

endmodule

`default_nettype wire

>>> hw/rtl/pbm_sqrt.sv
`default_nettype none

module pbm_sqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pbm_pkg::pbm_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pbm_pkg::pbm_item_t      out_item
);

  localparam int NS = pbm_pkg::ROOT_BITS;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vld_src;

  // Per-stage ready chain
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_src   = {vld[NS-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  // One root bit per stage: bring down two radicand bits, try root*4+1
  pbm_pkg::pbm_item_t itm [NS];
  logic [63:0] rad  [NS];
  logic [35:0] rem  [NS];
  logic [31:0] root [NS];

  pbm_pkg::pbm_item_t itm_s [NS];
  logic [63:0] rad_s  [NS];
  logic [35:0] rem_s  [NS];
  logic [31:0] root_s [NS];
  logic [35:0] cur    [NS];
  logic [35:0] trial  [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        itm_s[k]  = in_item;
        rad_s[k]  = in_item.s;
        rem_s[k]  = '0;
        root_s[k] = '0;
      end else begin
        itm_s[k]  = itm[k-1];
        rad_s[k]  = rad[k-1];
        rem_s[k]  = rem[k-1];
        root_s[k] = root[k-1];
      end
      cur[k]   = {rem_s[k][33:0], rad_s[k][63:62]};
      trial[k] = {2'b00, root_s[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        itm[k] <= itm_s[k];
        rad[k] <= {rad_s[k][61:0], 2'b00};
        if (cur[k] >= trial[k]) begin
          rem[k]  <= cur[k] - trial[k];
          root[k] <= {root_s[k][30:0], 1'b1};
        end else begin
          rem[k]  <= cur[k];
          root[k] <= {root_s[k][30:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    out_item   = itm[NS-1];
    out_item.n = root[NS-1];
  end

endmodule

`default_nettype wire

>>> hw/rtl/pbm_cordic.sv
`default_nettype none

module pbm_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pbm_pkg::pbm_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pbm_pkg::pbm_item_t      out_item
);

  localparam int NS = (STEPS > pbm_pkg::ATAN_LEN) ? pbm_pkg::ATAN_LEN : STEPS;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vld_src;

  // Per-stage ready chain
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_src   = {vld[NS-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  // Vectoring rotations on (wh, n), one micro-rotation per stage
  pbm_pkg::pbm_item_t itm [NS];
  logic signed [35:0] x [NS];
  logic signed [35:0] y [NS];
  logic signed [33:0] z [NS];

  pbm_pkg::pbm_item_t itm_s [NS];
  logic signed [35:0] x_s [NS];
  logic signed [35:0] y_s [NS];
  logic signed [33:0] z_s [NS];
  logic signed [35:0] xs  [NS];
  logic signed [35:0] ys  [NS];
  logic signed [33:0] at  [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        itm_s[k] = in_item;
        x_s[k]   = {4'b0000, in_item.wh};
        y_s[k]   = {4'b0000, in_item.n};
        z_s[k]   = '0;
      end else begin
        itm_s[k] = itm[k-1];
        x_s[k]   = x[k-1];
        y_s[k]   = y[k-1];
        z_s[k]   = z[k-1];
      end
      xs[k] = x_s[k] >>> k;
      ys[k] = y_s[k] >>> k;
      at[k] = {2'b00, pbm_pkg::ATAN_Q30[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        itm[k] <= itm_s[k];
        if (!y_s[k][35]) begin
          x[k] <= x_s[k] + ys[k];
          y[k] <= y_s[k] - xs[k];
          z[k] <= z_s[k] + at[k];
        end else begin
          x[k] <= x_s[k] - ys[k];
          y[k] <= y_s[k] + xs[k];
          z[k] <= z_s[k] - at[k];
        end
      end
    end
  end

  // Double the angle and clamp below at zero
  always_comb begin
    out_item       = itm[NS-1];
    out_item.theta = z[NS-1][33] ? 32'd0 : {z[NS-1][30:0], 1'b0};
  end

endmodule

`default_nettype wire

>>> hw/rtl/pbm_rot.sv
`default_nettype none

module pbm_rot #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pbm_pkg::pbm_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [159:0]            out_data
);

  localparam int QB = pbm_pkg::QUO_BITS;
  localparam int NS = QB + 2;
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam logic [32:0] RND = (SH > 0) ? (33'd1 << (SH - 1)) : 33'd0;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vld_src;

  // Per-stage ready chain
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_src   = {vld[NS-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  pbm_pkg::pbm_item_t itm [QB+1];
  logic [63:0] prod [3];

  // Restoring division by n, one quotient bit per stage in each lane
  logic [31:0] rem [QB][3];
  logic [31:0] lo  [QB][3];
  logic [31:0] rem_s [QB][3];
  logic [31:0] lo_s  [QB][3];
  logic [32:0] t     [QB][3];
  logic [32:0] den   [QB];
  logic        ge    [QB][3];

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      den[j] = {1'b0, itm[j].n};
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          rem_s[j][i] = prod[i][63:32];
          lo_s[j][i]  = prod[i][31:0];
        end else begin
          rem_s[j][i] = rem[j-1][i];
          lo_s[j][i]  = lo[j-1][i];
        end
        t[j][i]  = {rem_s[j][i], lo_s[j][i][31]};
        ge[j][i] = t[j][i] >= den[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    // Stage 0: numerators theta * u
    if (rdy[0]) begin
      itm[0] <= in_item;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= in_item.theta * in_item.u[i];
      end
    end
    for (int j = 0; j < QB; j++) begin
      if (rdy[j+1]) begin
        itm[j+1] <= itm[j];
        for (int i = 0; i < 3; i++) begin
          rem[j][i] <= ge[j][i] ? 32'(t[j][i] - den[j]) : t[j][i][31:0];
          lo[j][i]  <= {lo_s[j][i][30:0], ge[j][i]};
        end
      end
    end
  end

  // Final stage: round, saturate, apply sign, zero when n is zero
  logic [32:0] qr  [3];
  logic [18:0] rv  [3];
  logic        nz;

  always_comb begin
    nz = itm[QB].n != 32'd0;
    for (int i = 0; i < 3; i++) begin
      qr[i] = ({1'b0, lo[QB-1][i]} + RND) >> SH;
      if (!nz) begin
        rv[i] = '0;
      end else if (qr[i] > {14'd0, pbm_pkg::ROT_MAX}) begin
        rv[i] = itm[QB].neg[i] ? pbm_pkg::ROT_MIN : pbm_pkg::ROT_MAX;
      end else begin
        rv[i] = itm[QB].neg[i] ? -qr[i][18:0] : qr[i][18:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      out_data <= {4'b0000, rv[2], rv[1], rv[0],
                   itm[QB].diff[2], itm[QB].diff[1], itm[QB].diff[0]};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pose_box_minus.sv
// Pose difference: position y - x and rotation vector of conj(qx)*qy.
// Pipeline sections: product/sum, square root, arctangent, scaling/division.
// One item per cycle while m_tready is high; every stage holds its own item.
// Reset (rst, synchronous, active high) clears all stage valid bits.
`default_nettype none

module pose_box_minus #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pos_y_x, pos_y_y, pos_y_z, pos_x_x, pos_x_y, pos_x_z,
  // quat_y_xy, quat_y_zw, quat_x_xy, quat_x_zw (32 bits each)
  input  wire logic [319:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // diff_x, diff_y, diff_z (33 bits each), rot_x, rot_y, rot_z (19 bits each),
  // 4 zero bits
  output logic [159:0]      m_tdata
);

  logic q_valid, q_ready, r_valid, r_ready, c_valid, c_ready;
  pbm_pkg::pbm_item_t q_item, r_item, c_item;

  // Products, short-rotation flip and sum of squares
  pbm_quat u_quat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Vector norm
  pbm_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_item  (r_item)
  );

  // Rotation angle
  pbm_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_item   (r_item),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (c_item)
  );

  // Scale components by theta / n and format the result
  pbm_rot #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_item   (c_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

>>> test/tb_pose_box_minus.sv
`timescale 1ns / 100ps

module tb_pose_box_minus;

  localparam int LATENCY = 86;
  localparam int RANDOM_ITEMS = 2000;

  // Members from the top bit down: rot_z first, diff_x last
  typedef struct packed {
    logic signed [18:0] rz, ry, rx;
    logic signed [32:0] dz, dy, dx;
  } pose_diff_t;

  typedef struct {
    logic [31:0] py [3];
    logic [31:0] px [3];
    logic [15:0] qy [4];  // x, y, z, w
    logic [15:0] qx [4];
  } pose_pair_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [319:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;

  int errors = 0;

  pose_box_minus dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // floor shift of a signed value
  function automatic longint shr_floor(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint xv, longint yv);
    longint x, y, z, xs, ys;
    x = xv;
    y = yv;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(pbm_pkg::ATAN_Q30[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(pbm_pkg::ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [18:0] scale_component(longint comp, longint unsigned u,
                                                  longint unsigned theta,
                                                  longint unsigned n);
    longint unsigned q;
    q = (theta * u) / n;
    q = (q + (64'd1 << 13)) >> 14;
    if (q > 262143) return (comp < 0) ? pbm_pkg::ROT_MIN : pbm_pkg::ROT_MAX;
    return (comp < 0) ? 19'(-longint'(q)) : 19'(q);
  endfunction

  // Position difference and log map of conj(qx)*qy
  function automatic pose_diff_t pose_difference(pose_pair_t p);
    pose_diff_t r;
    longint ax, ay, az, aw, bx, by, bz, bw, w, wh, ang;
    longint v [3];
    longint unsigned u [3];
    longint unsigned s, n, mag;
    r.dx = $signed({p.py[0][31], p.py[0]}) - $signed({p.px[0][31], p.px[0]});
    r.dy = $signed({p.py[1][31], p.py[1]}) - $signed({p.px[1][31], p.px[1]});
    r.dz = $signed({p.py[2][31], p.py[2]}) - $signed({p.px[2][31], p.px[2]});
    bx = longint'($signed(p.qy[0])); by = longint'($signed(p.qy[1]));
    bz = longint'($signed(p.qy[2])); bw = longint'($signed(p.qy[3]));
    ax = longint'($signed(p.qx[0])); ay = longint'($signed(p.qx[1]));
    az = longint'($signed(p.qx[2])); aw = longint'($signed(p.qx[3]));
    w = aw * bw + ax * bx + ay * by + az * bz;
    v[0] = aw * bx - bw * ax - (ay * bz - az * by);
    v[1] = aw * by - bw * ay - (az * bx - ax * bz);
    v[2] = aw * bz - bw * az - (ax * by - ay * bx);
    if (w < 0) begin
      w = -w;
      for (int k = 0; k < 3; k++) v[k] = -v[k];
    end
    s = 0;
    for (int k = 0; k < 3; k++) begin
      mag = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
      u[k] = mag >> 1;
      s += u[k] * u[k];
    end
    n = floor_sqrt(s);
    if (n == 0) begin
      r.rx = '0; r.ry = '0; r.rz = '0;
      return r;
    end
    wh = w >>> 1;
    ang = 2 * vector_angle(wh, longint'(n));
    if (ang < 0) ang = 0;
    r.rx = scale_component(v[0], u[0], ang, n);
    r.ry = scale_component(v[1], u[1], ang, n);
    r.rz = scale_component(v[2], u[2], ang, n);
    return r;
  endfunction

  class diff_scoreboard;
    pose_diff_t pending[$];

    function void note_input(pose_pair_t p);
      pending.push_back(pose_difference(p));
    endfunction

    task check_result(logic [159:0] d);
      pose_diff_t got, want;
      got = d[155:0];
      if (d[159:156] != 4'b0) report("padding bits not zero");
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.dx !== want.dx) report($sformatf("diff_x %h want %h", got.dx, want.dx));
      if (got.dy !== want.dy) report($sformatf("diff_y %h want %h", got.dy, want.dy));
      if (got.dz !== want.dz) report($sformatf("diff_z %h want %h", got.dz, want.dz));
      if (got.rx !== want.rx) report($sformatf("rot_x %h want %h", got.rx, want.rx));
      if (got.ry !== want.ry) report($sformatf("rot_y %h want %h", got.ry, want.ry));
      if (got.rz !== want.rz) report($sformatf("rot_z %h want %h", got.rz, want.rz));
    endtask
  endclass

  diff_scoreboard board = new();
  int gap_left = 0;
  int burst_left = 0;

  function automatic logic [319:0] pack_pair(pose_pair_t p);
    return {p.qx[2], p.qx[3], p.qx[0], p.qx[1], p.qy[2], p.qy[3], p.qy[0], p.qy[1],
            p.px[2], p.px[1], p.px[0], p.py[2], p.py[1], p.py[0]};
  endfunction

  // Send one item, idling in bursts and gaps; called at a rising edge
  task automatic send_pair(pose_pair_t p);
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 20);
    end
    while (gap_left > 0) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_pair(p);
    board.note_input(p);
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  function automatic logic [15:0] pick_quat(int mode);
    case (mode)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(16384 - $urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  // Rotation near identity, with the scalar part of qx negated, extreme qy, or random
  function automatic pose_pair_t random_pair();
    pose_pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      p.py[k] = ($urandom_range(0, 9) == 0) ? {$urandom_range(0, 1) ? 32'h7FFFFFFF :
                32'h80000000} : $urandom;
      p.px[k] = $urandom;
    end
    for (int k = 0; k < 4; k++) begin
      p.qy[k] = 16'($urandom);
      p.qx[k] = 16'($urandom);
    end
    if (kind < 3) begin
      p.qx = p.qy;
      p.qx[$urandom_range(0, 3)] += 16'($urandom_range(0, 200)) - 16'd100;
    end else if (kind < 5) begin
      p.qx = p.qy;
      p.qx[3] = -p.qy[3] + 16'($urandom_range(0, 20));
    end else if (kind == 5) begin
      for (int k = 0; k < 4; k++) p.qy[k] = pick_quat($urandom_range(0, 4));
    end
    return p;
  endfunction

  // Receiver stall pattern
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (phase % 600 < 150) m_tready <= 1'b1;
      else if (phase % 600 < 200) m_tready <= 1'b0;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    pose_pair_t p;
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: position extremes, zero, identity, opposite and odd quaternions
    for (int t = 0; t < 20; t++) begin
      for (int k = 0; k < 3; k++) begin
        p.py[k] = (t % 2) ? 32'h7FFFFFFF : 32'h80000000;
        p.px[k] = (t % 2) ? 32'h80000000 : 32'h7FFFFFFF;
      end
      if (t >= 10) begin
        p.py[0] = 0; p.px[0] = 32'hFFFFFFFF;
      end
      for (int k = 0; k < 4; k++) begin
        p.qy[k] = pick_quat((t + k) % 5);
        p.qx[k] = pick_quat((t * 3 + k) % 5);
      end
      case (t)
        0: begin p.qy = '{0, 0, 0, 0}; p.qx = '{0, 0, 0, 0}; end
        1: begin p.qy = '{0, 0, 0, 16384}; p.qx = p.qy; end
        2: begin p.qy = '{16384, 0, 0, 0}; p.qx = '{0, 0, 0, 16384}; end
        3: begin p.qy = '{0, 0, 0, 16384}; p.qx = '{0, 0, 0, 16'hC000}; end
        4: begin p.qy = '{1, 0, 0, 16384}; p.qx = '{0, 0, 0, 16384}; end
        5: begin p.qy = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0}; p.qx = '{0, 0, 0, 1}; end
        6: begin p.qy = '{0, 16'h8000, 0, 0}; p.qx = '{0, 0, 0, 16'h8000}; end
        7: begin p.qy = '{0, 0, 11585, 11585}; p.qx = '{0, 0, 0, 16384}; end
        default: ;
      endcase
      send_pair(p);
    end
    s_tvalid <= 1'b0;

    // Hold off until the pipeline drains
    while (board.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) send_pair(random_pair());
    s_tvalid <= 1'b0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
